@@ rtl/core/br1_pkg.sv @@
package br1_pkg;

  localparam int unsigned MaxPlanesDefault = 8;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CFG_ROW_BYTES   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_PLANE_COUNT = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_HAS_MASK    = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_ROW_COUNT   = 2'd3;

  localparam logic [15:0] RowBytesReset   = 16'd40;
  localparam logic [3:0]  PlaneCountReset = 4'd8;
  localparam logic        HasMaskReset    = 1'b0;
  localparam logic [15:0] RowCountReset   = 16'd200;

  // Header byte that carries no run
  localparam logic [7:0] NopHeader = 8'h80;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_LITERAL = 2'd1,
    PH_REPEAT  = 2'd2,
    PH_DROP    = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_TRUNC = 2'd1,
    ST_SHORT = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       end_of_body;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [7:0] repeat_len;
    logic       done_res;
    status_e    status;
  } out_item_t;

  typedef struct packed {
    logic [15:0] row_bytes;
    logic [3:0]  plane_count;
    logic        has_mask;
    logic [15:0] row_count;
  } cfg_t;

  typedef struct packed {
    phase_e      phase;
    logic [7:0]  run_left;
    logic [16:0] seg_left;
    logic [15:0] rows_done;
    logic        finished;
  } dec_state_t;

endpackage

@@ rtl/core/br1_cfg_regs.sv @@
module br1_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [br1_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [br1_pkg::CfgDataW-1:0]    cfg_wdata_i,
  output br1_pkg::cfg_t                   cfg_o,
  output logic                            restart_o
);

  br1_pkg::cfg_t cfg_q, cfg_d;
  logic          restart_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        br1_pkg::CFG_ROW_BYTES:   cfg_d.row_bytes   = cfg_wdata_i[15:0];
        br1_pkg::CFG_PLANE_COUNT: cfg_d.plane_count = cfg_wdata_i[3:0];
        br1_pkg::CFG_HAS_MASK:    cfg_d.has_mask    = cfg_wdata_i[0];
        br1_pkg::CFG_ROW_COUNT:   cfg_d.row_count   = cfg_wdata_i[15:0];
        default:                  cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.row_bytes   <= br1_pkg::RowBytesReset;
      cfg_q.plane_count <= br1_pkg::PlaneCountReset;
      cfg_q.has_mask    <= br1_pkg::HasMaskReset;
      cfg_q.row_count   <= br1_pkg::RowCountReset;
      restart_q         <= 1'b0;
    end else begin
      cfg_q     <= cfg_d;
      // restart is registered, so it rises in the cycle after the write and the decoder sees the new values
      restart_q <= cfg_we_i;
    end
  end

  assign cfg_o     = cfg_q;
  assign restart_o = restart_q;

endmodule

@@ rtl/core/br1_step.sv @@
module br1_step #(
  parameter int unsigned MAX_PLANES = br1_pkg::MaxPlanesDefault,
  localparam int unsigned PIW = $clog2(MAX_PLANES + 2)
) (
  input  br1_pkg::cfg_t       cfg_i,
  input  br1_pkg::dec_state_t st_i,
  input  logic [PIW-1:0]      plane_i,
  input  br1_pkg::in_item_t   item_i,
  output br1_pkg::dec_state_t st_o,
  output logic [PIW-1:0]      plane_o,
  output logic                res_valid_o,
  output br1_pkg::out_item_t  res_o,
  output logic [16:0]         seg_len_o
);

  logic [16:0]    seg_len;
  logic [16:0]    pad17;
  logic [PIW-1:0] eff_planes;
  logic [PIW-1:0] plane_limit;
  logic           empty_img;
  logic           last_seg;
  logic           image_plane;
  logic [16:0]    run17;
  logic [16:0]    cnt;
  logic [16:0]    after;
  logic [16:0]    emit;
  logic [7:0]     run_dec;
  logic [16:0]    seg_dec1;

  assign seg_len   = {1'b0, cfg_i.row_bytes} + 17'(cfg_i.row_bytes[0]);
  assign seg_len_o = seg_len;
  assign pad17     = 17'(cfg_i.row_bytes[0]);
  assign eff_planes = (cfg_i.plane_count > 4'(MAX_PLANES)) ? PIW'(MAX_PLANES)
                                                           : PIW'(cfg_i.plane_count);
  assign plane_limit = eff_planes + PIW'(cfg_i.has_mask);
  assign empty_img   = (cfg_i.row_bytes == '0) || (cfg_i.plane_count == '0) ||
                       (cfg_i.row_count == '0);
  assign last_seg    = ((plane_i + PIW'(1)) == eff_planes) &&
                       (({1'b0, st_i.rows_done} + 17'd1) == {1'b0, cfg_i.row_count});
  assign image_plane = plane_i < eff_planes;

  assign run17    = {9'b0, st_i.run_left};
  assign cnt      = (run17 < st_i.seg_left) ? run17 : st_i.seg_left;
  assign after    = st_i.seg_left - cnt;
  assign emit     = (after >= pad17) ? cnt : cnt - 17'd1;
  assign run_dec  = st_i.run_left - 8'd1;
  assign seg_dec1 = st_i.seg_left - 17'd1;

  logic        have;
  logic        done;
  logic [7:0]  len;
  logic        adv_en;
  logic [16:0] adv_k;
  logic [16:0] seg_sub;
  logic [PIW-1:0] plane_inc;

  always_comb begin
    st_o        = st_i;
    plane_o     = plane_i;
    have        = 1'b0;
    done        = 1'b0;
    len         = '0;
    adv_en      = 1'b0;
    adv_k       = '0;
    seg_sub     = '0;
    plane_inc   = '0;
    res_valid_o = 1'b0;
    res_o.out_byte   = '0;
    res_o.repeat_len = '0;
    res_o.done_res   = 1'b0;
    res_o.status     = br1_pkg::ST_OK;

    if (st_i.finished) begin
      res_valid_o = 1'b0;
    end else if (empty_img) begin
      st_o.finished  = 1'b1;
      res_valid_o    = 1'b1;
      res_o.done_res = 1'b1;
    end else begin
      case (st_i.phase)
        br1_pkg::PH_HEADER: begin
          if (!item_i.code_byte[7]) begin
            st_o.run_left = item_i.code_byte + 8'd1;
            st_o.phase    = br1_pkg::PH_LITERAL;
          end else if (item_i.code_byte != br1_pkg::NopHeader) begin
            st_o.run_left = 8'd1 - item_i.code_byte;
            st_o.phase    = br1_pkg::PH_REPEAT;
          end
        end
        br1_pkg::PH_LITERAL: begin
          if (image_plane && (st_i.seg_left > pad17)) begin
            have = 1'b1;
            len  = 8'd1;
            if ((seg_dec1 <= pad17) && last_seg) begin
              done = 1'b1;
            end
          end
          st_o.run_left = run_dec;
          if (run_dec == '0) begin
            st_o.phase = br1_pkg::PH_HEADER;
          end else if (st_i.seg_left == 17'd1) begin
            // run crosses the segment end: swallow the excess literals
            st_o.phase = br1_pkg::PH_DROP;
          end
          adv_en = 1'b1;
          adv_k  = 17'd1;
        end
        br1_pkg::PH_REPEAT: begin
          if (image_plane && (emit != '0)) begin
            have = 1'b1;
            len  = emit[7:0];
            if ((after <= pad17) && last_seg) begin
              done = 1'b1;
            end
          end
          st_o.run_left = '0;
          st_o.phase    = br1_pkg::PH_HEADER;
          adv_en        = 1'b1;
          adv_k         = cnt;
        end
        br1_pkg::PH_DROP: begin
          st_o.run_left = run_dec;
          if (run_dec == '0) begin
            st_o.phase = br1_pkg::PH_HEADER;
          end
        end
        default: st_o = st_i;
      endcase

      // step through segments, planes and rows
      if (adv_en) begin
        seg_sub = st_i.seg_left - adv_k;
        if (seg_sub == '0) begin
          st_o.seg_left = seg_len;
          plane_inc     = plane_i + PIW'(1);
          if (plane_inc >= plane_limit) begin
            plane_o        = '0;
            st_o.rows_done = st_i.rows_done + 16'd1;
          end else begin
            plane_o = plane_inc;
          end
        end else begin
          st_o.seg_left = seg_sub;
        end
      end

      if (done) begin
        st_o.finished = 1'b1;
      end else if (item_i.end_of_body) begin
        st_o.finished = 1'b1;
        done          = 1'b1;
        res_o.status  = (st_o.phase != br1_pkg::PH_HEADER) ? br1_pkg::ST_TRUNC
                                                           : br1_pkg::ST_SHORT;
      end

      res_valid_o      = have || done;
      res_o.out_byte   = have ? item_i.code_byte : 8'd0;
      res_o.repeat_len = have ? len : 8'd0;
      res_o.done_res   = done;
    end
  end

endmodule

@@ rtl/core/byterun1_plane_row_decoder.sv @@
// ByteRun1 (PackBits) plane-row decoder. Takes one compressed body byte per
// item and returns at most one result per byte: a byte value with the number
// of times it is written (repeat_len 0 marks a status-only result), done_res on
// the last result of the image, and a status of ok, truncated run or short
// body. Throughput is one item per clock while the output is not stalled; a
// byte moves through an input register and the decode logic into the result
// register. Runs are clamped at each plane row segment, mask-plane and
// odd-width pad bytes are discarded, and after the final result all further
// items are taken and ignored until the next configuration write or reset. A
// configuration write restarts decoding; allow one cycle after it before the
// first item.
module byterun1_plane_row_decoder #(
  parameter int unsigned MAX_PLANES = br1_pkg::MaxPlanesDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  br1_pkg::in_item_t            in_item_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output br1_pkg::out_item_t           out_item_o,
  input  logic                         cfg_we_i,
  input  logic [br1_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [br1_pkg::CfgDataW-1:0] cfg_wdata_i
);

  localparam int unsigned PIW = $clog2(MAX_PLANES + 2);

  br1_pkg::cfg_t       cfg;
  logic                restart;
  br1_pkg::dec_state_t st_q, st_d, st_next;
  logic [PIW-1:0]      plane_q, plane_d, plane_next;
  logic                res_valid;
  br1_pkg::out_item_t  res;
  logic [16:0]         seg_len;

  logic                in_valid_q;
  br1_pkg::in_item_t   in_item_q;
  logic                out_valid_q, out_valid_d;
  br1_pkg::out_item_t  out_item_q;
  logic                out_free;
  logic                proc;

  br1_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg),
    .restart_o   (restart)
  );

  br1_step #(
    .MAX_PLANES (MAX_PLANES)
  ) u_step (
    .cfg_i       (cfg),
    .st_i        (st_q),
    .plane_i     (plane_q),
    .item_i      (in_item_q),
    .st_o        (st_next),
    .plane_o     (plane_next),
    .res_valid_o (res_valid),
    .res_o       (res),
    .seg_len_o   (seg_len)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign proc       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;

  always_comb begin
    st_d    = st_q;
    plane_d = plane_q;
    if (restart) begin
      st_d.phase     = br1_pkg::PH_HEADER;
      st_d.run_left  = '0;
      st_d.seg_left  = seg_len;
      st_d.rows_done = '0;
      st_d.finished  = 1'b0;
      plane_d        = '0;
    end else if (proc) begin
      st_d    = st_next;
      plane_d = plane_next;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_free) begin
      out_valid_d = proc && res_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.phase     <= br1_pkg::PH_HEADER;
      st_q.run_left  <= '0;
      st_q.seg_left  <= {1'b0, br1_pkg::RowBytesReset} + 17'(br1_pkg::RowBytesReset[0]);
      st_q.rows_done <= '0;
      st_q.finished  <= 1'b0;
      plane_q        <= '0;
      in_valid_q     <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      st_q        <= st_d;
      plane_q     <= plane_d;
      out_valid_q <= out_valid_d;
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
    end
  end

  // payload registers: load on acceptance only
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_item_q <= in_item_i;
    end
    if (proc && res_valid) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

@@ verif/byterun1_plane_row_decoder_tb.sv @@
`timescale 1ns / 100ps

module byterun1_plane_row_decoder_tb;
  import br1_pkg::*;

  localparam int unsigned MAX_PLANES = MaxPlanesDefault;
  localparam int RANDOM_BYTES = 1600;
  localparam int QUIET_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 6;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  in_item_t            in_item_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_item_t           out_item_o;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;

  byterun1_plane_row_decoder u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  in_item_t  stage_q[$];    // body under construction
  in_item_t  body_q[$];     // body bytes waiting for the driver
  out_item_t decoded_q[$];  // decoded results not yet seen

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;
  int bad_count = 0;
  int results_checked = 0;
  int bytes_sent = 0;
  int images_run = 0;

  // register copies
  logic [15:0] mir_row_bytes;
  logic [3:0]  mir_planes;
  logic        mir_mask;
  logic [15:0] mir_rows;

  // decoder state copy
  phase_e      dec_phase;
  logic [7:0]  dec_run;
  logic [16:0] dec_seg;
  logic [3:0]  dec_plane;
  logic [15:0] dec_rows;
  logic        dec_done;

  function automatic int unsigned planes_used();
    return (mir_planes > MAX_PLANES) ? MAX_PLANES : int'(mir_planes);
  endfunction

  function automatic int unsigned seg_size();
    return mir_row_bytes + mir_row_bytes[0];
  endfunction

  function automatic bit at_last_segment();
    return (dec_plane + 1 == planes_used()) && (dec_rows + 1 == mir_rows);
  endfunction

  task automatic restart_decode();
    dec_phase = PH_HEADER;
    dec_run   = '0;
    dec_seg   = 17'(seg_size());
    dec_plane = '0;
    dec_rows  = '0;
    dec_done  = 1'b0;
  endtask

  task automatic step_segment(input int unsigned k);
    dec_seg = 17'(dec_seg - k);
    if (dec_seg == 0) begin
      dec_seg = 17'(seg_size());
      dec_plane = dec_plane + 4'd1;
      if (dec_plane >= planes_used() + mir_mask) begin
        dec_plane = '0;
        dec_rows = dec_rows + 16'd1;
      end
    end
  endtask

  task automatic decode_byte(input in_item_t it, output bit got, output out_item_t res);
    logic [7:0]  b;
    bit          have;
    bit          done;
    int unsigned len;
    int unsigned pad;
    int unsigned cnt;
    int unsigned after;
    int unsigned emit;
    status_e     st;
    b = it.code_byte;
    have = 1'b0;
    done = 1'b0;
    len = 0;
    pad = mir_row_bytes[0];
    st = ST_OK;
    got = 1'b0;
    res = '0;
    if (dec_done) return;
    if (mir_row_bytes == 0 || mir_planes == 0 || mir_rows == 0) begin
      dec_done = 1'b1;
      got = 1'b1;
      res.done_res = 1'b1;
      res.status = ST_OK;
      return;
    end
    case (dec_phase)
      PH_HEADER: begin
        if (b < 8'd128) begin
          dec_run = 8'(int'(b) + 1);
          dec_phase = PH_LITERAL;
        end else if (b != NopHeader) begin
          dec_run = 8'(257 - int'(b));
          dec_phase = PH_REPEAT;
        end
      end
      PH_LITERAL: begin
        if (dec_plane < planes_used() && dec_seg > pad) begin
          have = 1'b1;
          len = 1;
          if (dec_seg - 1 <= pad && at_last_segment()) done = 1'b1;
        end
        dec_run = dec_run - 8'd1;
        if (dec_run == 0) dec_phase = PH_HEADER;
        else if (dec_seg == 1) dec_phase = PH_DROP;
        step_segment(1);
      end
      PH_REPEAT: begin
        cnt = (dec_run < dec_seg) ? dec_run : dec_seg;
        after = dec_seg - cnt;
        emit = (after >= pad) ? cnt : cnt - 1;
        if (dec_plane < planes_used() && emit > 0) begin
          have = 1'b1;
          len = emit;
          if (after <= pad && at_last_segment()) done = 1'b1;
        end
        dec_run = '0;
        dec_phase = PH_HEADER;
        step_segment(cnt);
      end
      default: begin
        dec_run = dec_run - 8'd1;
        if (dec_run == 0) dec_phase = PH_HEADER;
      end
    endcase
    if (done) begin
      dec_done = 1'b1;
    end else if (it.end_of_body) begin
      dec_done = 1'b1;
      done = 1'b1;
      st = (dec_phase != PH_HEADER) ? ST_TRUNC : ST_SHORT;
    end
    if (!have && !done) return;
    got = 1'b1;
    res.out_byte = have ? b : 8'd0;
    res.repeat_len = have ? 8'(len) : 8'd0;
    res.done_res = done;
    res.status = st;
  endtask

  task automatic flag_error(input string msg);
    bad_count++;
    if (bad_count <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  // driver: advance to the next body byte once the current one is taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_item_i <= '0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (body_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        in_item_i <= body_q.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  bit        got_one;
  out_item_t predicted;
  out_item_t want;

  // monitor: predict on every accepted byte, then check the accepted result
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      decode_byte(in_item_i, got_one, predicted);
      if (got_one) decoded_q.push_back(predicted);
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (decoded_q.size() == 0) begin
        flag_error($sformatf("unexpected result: byte %02h len %0d done %0b status %0d",
                             out_item_o.out_byte, out_item_o.repeat_len,
                             out_item_o.done_res, out_item_o.status));
      end else begin
        want = decoded_q.pop_front();
        results_checked++;
        if (out_item_o.out_byte !== want.out_byte ||
            out_item_o.repeat_len !== want.repeat_len ||
            out_item_o.done_res !== want.done_res ||
            out_item_o.status !== want.status) begin
          flag_error($sformatf({"result %0d mismatch: expected byte %02h len %0d done %0b ",
                                "status %0d, got byte %02h len %0d done %0b status %0d"},
                               results_checked, want.out_byte, want.repeat_len,
                               want.done_res, want.status, out_item_o.out_byte,
                               out_item_o.repeat_len, out_item_o.done_res,
                               out_item_o.status));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("byterun1_plane_row_decoder_tb: errors");
      $finish;
    end
  end

  task automatic wait_idle();
    @(negedge clk_i);
    while (body_q.size() != 0 || in_valid_i || decoded_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [15:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= value;
    case (idx)
      CFG_ROW_BYTES:   mir_row_bytes = value;
      CFG_PLANE_COUNT: mir_planes = value[3:0];
      CFG_HAS_MASK:    mir_mask = value[0];
      default:         mir_rows = value;
    endcase
    restart_decode();
  endtask

  task automatic set_config(input logic [15:0] rb, input logic [3:0] pc, input logic mk,
                            input logic [15:0] rc);
    wait_idle();
    write_reg(CFG_ROW_BYTES, rb);
    write_reg(CFG_PLANE_COUNT, {12'd0, pc});
    write_reg(CFG_HAS_MASK, {15'd0, mk});
    write_reg(CFG_ROW_COUNT, rc);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic put_byte(input logic [7:0] code, input logic eob);
    in_item_t it;
    it.code_byte = code;
    it.end_of_body = eob;
    stage_q.push_back(it);
  endtask

  task automatic mark_last_eob();
    in_item_t it;
    it = stage_q.pop_back();
    it.end_of_body = 1'b1;
    stage_q.push_back(it);
  endtask

  // hand the staged body to the driver, optionally draining halfway through
  task automatic send_body(input bit drain_mid);
    int n;
    int i;
    n = stage_q.size();
    @(negedge clk_i);
    for (i = 0; i < n; i++) begin
      if (drain_mid && i == n / 2) wait_idle();
      body_q.push_back(stage_q[i]);
    end
    bytes_sent += n;
    images_run++;
  endtask

  // well-formed runs that cover the image up to the byte budget, clamping some at segment ends
  task automatic build_image(input int budget);
    int unsigned seg_full;
    int unsigned pad;
    int unsigned segs;
    int unsigned r;
    int unsigned len;
    int unsigned c;
    int unsigned nb;
    int unsigned k;
    bit          fin;
    pad = mir_row_bytes[0];
    seg_full = seg_size();
    segs = (mir_rows - 1) * (planes_used() + mir_mask) + planes_used();
    r = seg_full;
    fin = 1'b0;
    while (!fin && stage_q.size() < budget) begin
      if ($urandom_range(99) < 5) put_byte(NopHeader, 1'b0);
      k = $urandom_range(99);
      if (k < 72) len = $urandom_range((r > 128) ? 128 : r, 1);
      else if (k < 94) len = r + $urandom_range(6, 1);
      else len = $urandom_range(128, 1);
      if (len > 128) len = 128;
      c = (len < r) ? len : r;
      r = r - c;
      fin = (segs == 1 && r <= pad);
      if (len == 1 || $urandom_range(1) == 0) begin
        nb = len;
        // stop at the last image byte; the pad position would be ignored
        if (fin) nb = (r < pad) ? c - (pad - r) : c;
        put_byte(8'(len - 1), 1'b0);
        repeat (nb) put_byte(8'($urandom), 1'b0);
      end else begin
        put_byte(8'(257 - len), 1'b0);
        put_byte(8'($urandom), 1'b0);
      end
      if (r == 0) begin
        segs = segs - 1;
        r = seg_full;
      end
    end
  endtask

  task automatic put_noise(input int n);
    repeat (n) put_byte(8'($urandom), ($urandom_range(9) == 0));
  endtask

  task automatic run_image(input bit drain_mid);
    int          k;
    int          m;
    int          cut;
    logic [15:0] rb;
    logic [3:0]  pc;
    logic        mk;
    logic [15:0] rc;
    bit          empty_cfg;
    bit          oversize;
    empty_cfg = 1'b0;
    oversize = 1'b0;
    mk = 1'($urandom_range(1));
    k = $urandom_range(99);
    if (k < 4) begin
      empty_cfg = 1'b1;
      rb = 16'($urandom_range(3));
      pc = 4'($urandom_range(2));
      rc = 16'($urandom_range(2));
      case ($urandom_range(2))
        0: rb = '0;
        1: pc = '0;
        default: rc = '0;
      endcase
    end else if (k < 10) begin
      oversize = 1'b1;
      rb = $urandom_range(1) ? 16'hFFFF : 16'($urandom_range(65535, 1000));
      pc = $urandom_range(1) ? 4'd8 : 4'($urandom_range(15, 1));
      rc = $urandom_range(1) ? 16'hFFFF : 16'($urandom_range(65535, 1));
    end else if (k < 18) begin
      rb = 16'($urandom_range(3, 1));
      pc = 4'($urandom_range(15, 8));
      rc = 16'd1;
    end else begin
      rb = ($urandom_range(9) == 0) ? 16'($urandom_range(40, 10)) : 16'($urandom_range(9, 1));
      pc = 4'($urandom_range(4, 1));
      rc = 16'($urandom_range(3, 1));
    end
    set_config(rb, pc, mk, rc);
    stage_q.delete();
    m = $urandom_range(99);
    if (empty_cfg) begin
      put_noise($urandom_range(2, 1));
    end else if (oversize) begin
      build_image($urandom_range(40, 10));
    end else if (m < 12) begin
      put_noise($urandom_range(20, 3));
    end else begin
      build_image(100000);
      if (m >= 82) begin
        cut = $urandom_range(stage_q.size(), 1);
        while (stage_q.size() > cut) void'(stage_q.pop_back());
      end else if (m >= 70) begin
        put_noise($urandom_range(3, 1));
      end
    end
    mark_last_eob();
    send_body(drain_mid);
  endtask

  initial begin
    int idle_mix[4];
    int stall_mix[4];
    int p;
    int start_bytes;
    bit first;
    idle_mix = '{0, 76, 0, 26};
    stall_mix = '{0, 0, 76, 26};
    mir_row_bytes = RowBytesReset;
    mir_planes = PlaneCountReset;
    mir_mask = HasMaskReset;
    mir_rows = RowCountReset;
    restart_decode();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: skip header, clamped repeat, then a short body
    stage_q.delete();
    put_byte(NopHeader, 1'b0);
    put_byte(8'h81, 1'b0);
    put_byte(8'hFF, 1'b0);
    put_byte(8'h00, 1'b0);
    put_byte(8'h00, 1'b1);
    send_body(1'b0);

    // odd width with mask: pad and excess literals dropped, mask discarded, finish
    set_config(16'd3, 4'd1, 1'b1, 16'd2);
    stage_q.delete();
    put_byte(8'h05, 1'b0);
    put_byte(8'h11, 1'b0);
    put_byte(8'h22, 1'b0);
    put_byte(8'h33, 1'b0);
    put_byte(8'h44, 1'b0);
    put_byte(8'h55, 1'b0);
    put_byte(8'h66, 1'b0);
    put_byte(8'hFD, 1'b0);
    put_byte(8'h77, 1'b0);
    put_byte(8'h7F, 1'b0);
    put_byte(8'hA5, 1'b0);
    put_byte(8'h5A, 1'b0);
    put_byte(8'hFF, 1'b0);
    put_byte(8'h00, 1'b1);
    send_body(1'b0);

    // body ends inside an open run
    set_config(16'd2, 4'd1, 1'b1, 16'd2);
    stage_q.delete();
    put_byte(8'h03, 1'b0);
    put_byte(8'hAA, 1'b1);
    send_body(1'b0);

    // empty images
    set_config(16'd0, 4'd2, 1'b0, 16'd1);
    stage_q.delete();
    put_byte(8'h00, 1'b0);
    send_body(1'b0);
    set_config(16'd5, 4'd0, 1'b0, 16'd1);
    stage_q.delete();
    put_byte(8'h00, 1'b0);
    send_body(1'b0);
    set_config(16'd5, 4'd3, 1'b1, 16'd0);
    stage_q.delete();
    put_byte(8'h00, 1'b0);
    send_body(1'b0);

    for (p = 0; p < 4; p++) begin
      wait_idle();
      send_idle_pct = idle_mix[p];
      recv_stall_pct = stall_mix[p];
      start_bytes = bytes_sent;
      first = 1'b1;
      while (bytes_sent - start_bytes < RANDOM_BYTES / 4) begin
        run_image(first || $urandom_range(99) < 6);
        first = 1'b0;
      end
    end

    wait_idle();
    repeat (8) @(posedge clk_i);
    if (decoded_q.size() != 0) flag_error($sformatf("%0d results never arrived", decoded_q.size()));
    $display("covered %0d images, %0d body bytes, %0d results checked, %0d mismatches",
             images_run, bytes_sent, results_checked, bad_count);
    $display("mixes: free flow, sender gaps, receiver stalls, both; odd, masked and empty setups");
    if (bad_count == 0) begin
      $display("byterun1_plane_row_decoder_tb: clean");
    end else begin
      $display("byterun1_plane_row_decoder_tb: errors");
    end
    $finish;
  end

endmodule
